// ----- rtl/su_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// su_pkg
// shared types and constants for the sorted unique table
// ----------------------------------------------------------------------------
package su_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int RANK_W  = 6;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 48;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    eval;
    logic                    do_ins;
    logic                    do_rm;
    logic signed [VAL_W-1:0] key;
    logic [IDX_W-1:0]        rank;
  } cell_ctl_t;

endpackage

// ----- rtl/su_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// su_cell
// one table slot: holds a value, compares it with the broadcast key and
// shifts with its neighbors on insert and remove
// ----------------------------------------------------------------------------
module su_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [su_pkg::IDX_W-1:0]         index,
  input  su_pkg::cell_ctl_t                ctl,
  input  logic signed [su_pkg::VAL_W-1:0]  left_value,
  input  logic                             left_valid,
  input  logic                             left_ins,
  input  logic signed [su_pkg::VAL_W-1:0]  right_value,
  input  logic                             right_valid,
  output logic signed [su_pkg::VAL_W-1:0]  value,
  output logic                             valid,
  output logic                             ins,
  output logic                             eq,
  output logic signed [su_pkg::VAL_W-1:0]  tap
);

  logic hit;
  logic rm;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ins   <= 1'b0;
      eq    <= 1'b0;
      hit   <= 1'b0;
      rm    <= 1'b0;
    end else begin
      if (ctl.eval) begin
        ins <= !valid || (value > ctl.key);
        eq  <= valid && (value == ctl.key);
        hit <= (index == ctl.rank);
        rm  <= (index >= ctl.rank);
      end
      if (ctl.do_ins && ins) begin
        valid <= valid | left_valid;
      end else if (ctl.do_rm && rm) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_ins && ins) begin
      value <= left_ins ? left_value : ctl.key;
    end else if (ctl.do_rm && rm) begin
      value <= right_value;
    end
  end

  assign tap = hit ? value : '0;

endmodule

// ----- rtl/sorted_unique_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_table
// ascending table of unique signed 32-bit values with insert, remove and
// read by rank
// ----------------------------------------------------------------------------
// The table is a row of 64 cells. An accepted word is first latched; then
// every cell compares the key and rank against its own slot; then the
// cells shift left or right together and the result word is loaded. The
// next word is taken once the block is back in idle, so the block takes no
// new word before it is through with the last one; a waiting result holds
// off the shift step only. Every result carries the entry count after the
// action.
module sorted_unique_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action [1:0], value [33:2], rank [39:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value [31:0], entry_count [38:32], status [40:39], zero fill above
  output logic [47:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  state_t                              state;
  su_pkg::action_t                     action_q;
  logic signed [su_pkg::VAL_W-1:0]     key_q;
  logic [su_pkg::IDX_W-1:0]            rank_q;
  logic [su_pkg::CNT_W-1:0]            count;
  logic signed [su_pkg::VAL_W-1:0]     out_value;
  logic [su_pkg::CNT_W-1:0]            out_count;
  su_pkg::status_t                     out_status;

  su_pkg::cell_ctl_t                   ctl;
  logic signed [su_pkg::VAL_W-1:0]     cell_value [su_pkg::DEPTH];
  logic signed [su_pkg::VAL_W-1:0]     cell_tap   [su_pkg::DEPTH];
  logic [su_pkg::DEPTH-1:0]            valid_vec;
  logic [su_pkg::DEPTH-1:0]            ins_vec;
  logic [su_pkg::DEPTH-1:0]            eq_vec;
  logic signed [su_pkg::VAL_W-1:0]     rd_value;

  logic                                can_out;
  logic                                dup;
  logic                                full;
  logic                                in_range;
  logic                                do_ins;
  logic                                do_rm;
  logic signed [su_pkg::VAL_W-1:0]     res_value;
  logic [su_pkg::CNT_W-1:0]            count_next;
  su_pkg::status_t                     res_status;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, out_status, out_count, out_value};
  assign can_out  = (state == S_APPLY) && (!m_tvalid || m_tready);

  assign dup      = |eq_vec;
  assign full     = (count == su_pkg::CNT_W'(su_pkg::DEPTH));
  assign in_range = ({1'b0, rank_q} < count);

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < su_pkg::DEPTH; i++) begin
      rd_value = rd_value | cell_tap[i];
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_rm      = 1'b0;
    res_value  = '0;
    res_status = su_pkg::ST_OK;
    count_next = count;
    case (action_q)
      su_pkg::ACT_INSERT: begin
        if (dup) begin
          res_status = su_pkg::ST_DUP;
        end else if (full) begin
          res_status = su_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      su_pkg::ACT_REMOVE: begin
        if (!in_range) begin
          res_status = su_pkg::ST_RANGE;
        end else begin
          do_rm      = 1'b1;
          res_value  = rd_value;
          count_next = count - 1'b1;
        end
      end
      su_pkg::ACT_READ: begin
        if (!in_range) begin
          res_status = su_pkg::ST_RANGE;
        end else begin
          res_value = rd_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.eval   = (state == S_EVAL);
    ctl.do_ins = can_out && do_ins;
    ctl.do_rm  = can_out && do_rm;
    ctl.key    = key_q;
    ctl.rank   = rank_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (can_out) begin
            m_tvalid <= 1'b1;
            count    <= count_next;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action_q <= su_pkg::action_t'(s_tdata[1:0]);
      key_q    <= $signed(s_tdata[33:2]);
      rank_q   <= s_tdata[39:34];
    end
    if (can_out) begin
      out_value  <= res_value;
      out_count  <= count_next;
      out_status <= res_status;
    end
  end

  for (genvar i = 0; i < su_pkg::DEPTH; i++) begin : g_cell
    logic signed [su_pkg::VAL_W-1:0] lv;
    logic                            lval;
    logic                            lins;
    logic signed [su_pkg::VAL_W-1:0] rv;
    logic                            rval;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lval = 1'b1;
      assign lins = 1'b0;
    end else begin : g_mid_l
      assign lv   = cell_value[i-1];
      assign lval = valid_vec[i-1];
      assign lins = ins_vec[i-1];
    end

    if (i == su_pkg::DEPTH - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_mid_r
      assign rv   = cell_value[i+1];
      assign rval = valid_vec[i+1];
    end

    su_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (su_pkg::IDX_W'(i)),
      .ctl         (ctl),
      .left_value  (lv),
      .left_valid  (lval),
      .left_ins    (lins),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[i]),
      .valid       (valid_vec[i]),
      .ins         (ins_vec[i]),
      .eq          (eq_vec[i]),
      .tap         (cell_tap[i])
    );
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= su_pkg::CNT_W'(su_pkg::DEPTH))
    else $error("entry count above depth");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid bits disagree with count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("valid cells not packed at the low end");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == su_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

  a_apply_exit: assert property (@(posedge clk) disable iff (rst)
    can_out |=> (state == S_IDLE) && m_tvalid)
    else $error("result not loaded after shift step");

endmodule
